>>> hdl/m4inv_pkg.sv
// Package for the 4x4 matrix inverse block: sequencer states, unit commands and
// the cofactor index tables. No dependencies.
package m4inv_pkg;

   localparam int DEF_ELEMENT_BITS = 32;
   localparam int DEF_FRAC_BITS    = 16;
   localparam int MAT_SIZE         = 16;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RD_A,
      ST_RD_B,
      ST_MUL1_GO,
      ST_MUL1,
      ST_MUL2,
      ST_COF_DONE,
      ST_DET_GO,
      ST_DET_MUL,
      ST_DET_CHECK,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_MUL,
      ALU_DIV
   } alu_mode_type;

   typedef struct packed {
      logic mul_start;
      logic div_start;
   } alu_cmd_type;

   // The k-th of the three indexes left after skipping index s.
   function automatic logic [1:0] pick(input logic [1:0] k, input logic [1:0] s);
      pick = (k < s) ? k : k + 2'd1;
   endfunction

   // Column chosen for row k by permutation term t of a 3x3 determinant.
   function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] k);
      logic [5:0] p;
      unique case (t)
         3'd0: p = {2'd2, 2'd1, 2'd0};
         3'd1: p = {2'd0, 2'd2, 2'd1};
         3'd2: p = {2'd1, 2'd0, 2'd2};
         3'd3: p = {2'd1, 2'd2, 2'd0};
         3'd4: p = {2'd0, 2'd1, 2'd2};
         3'd5: p = {2'd2, 2'd0, 2'd1};
         default: p = {2'd2, 2'd1, 2'd0};
      endcase
      perm_col = p[{k, 1'b0} +: 2];
   endfunction

   function automatic logic perm_odd(input logic [2:0] t);
      perm_odd = (t >= 3'd3);
   endfunction

   // Flat index of factor k of term t for the adjugate entry at flat index i.
   function automatic logic [3:0] flat_index(input logic [3:0] i, input logic [2:0] t,
                                             input logic [1:0] k);
      logic [1:0] row;
      logic [1:0] col;
      row = pick(k, i[1:0]);
      col = pick(perm_col(t, k), i[3:2]);
      flat_index = {row, col};
   endfunction

endpackage

>>> hdl/m4inv_alu.sv
// Shared bit-serial arithmetic unit: signed multiply and restoring divide over
// one wide adder. Depends on m4inv_pkg.
module m4inv_alu #(
   parameter int ELEMENT_BITS = m4inv_pkg::DEF_ELEMENT_BITS,
   parameter int FRAC_BITS    = m4inv_pkg::DEF_FRAC_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  m4inv_pkg::alu_cmd_type                      cmd,
   input  logic signed [4*ELEMENT_BITS+2*FRAC_BITS+3:0] opa,
   input  logic signed [ELEMENT_BITS-1:0]              opb,
   input  logic        [4*ELEMENT_BITS+2*FRAC_BITS+3:0] dmag,
   output logic signed [4*ELEMENT_BITS+2*FRAC_BITS+3:0] prod,
   output logic        [ELEMENT_BITS:0]                quot,
   output logic                                        quot_ovf,
   output logic                                        busy
);
   import m4inv_pkg::*;

   localparam int WIDE     = 4*ELEMENT_BITS + 2*FRAC_BITS + 4;
   localparam int CNT_BITS = $clog2(WIDE + 1);

   alu_mode_type                mode_ff, mode_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic [WIDE-1:0]             mcand_ff, mcand_in;
   logic [ELEMENT_BITS-1:0]     mplier_ff, mplier_in;
   logic [WIDE-1:0]             acc_ff, acc_in;
   logic [ELEMENT_BITS:0]       q_ff, q_in;
   logic                        ovf_ff, ovf_in;
   logic [WIDE:0]               add_x, add_y;
   logic                        add_cin;
   logic [WIDE+1:0]             sum;
   logic                        last_step;

   assign last_step = (cnt_ff == CNT_BITS'(1));
   assign sum = (WIDE+2)'(add_x) + (WIDE+2)'(add_y) + (WIDE+2)'(add_cin);

   always_comb begin
      add_x   = {acc_ff[WIDE-1], acc_ff};
      add_y   = last_step ? ~{mcand_ff[WIDE-1], mcand_ff} : {mcand_ff[WIDE-1], mcand_ff};
      add_cin = last_step;
      if (mode_ff == ALU_DIV) begin
         add_x   = {acc_ff, mcand_ff[WIDE-1]};
         add_y   = ~{1'b0, dmag};
         add_cin = 1'b1;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      q_in      = q_ff;
      ovf_in    = ovf_ff;
      unique case (mode_ff)
         ALU_IDLE: begin
            if (cmd.mul_start) begin
               mcand_in  = opa;
               mplier_in = opb;
               acc_in    = '0;
               cnt_in    = CNT_BITS'(ELEMENT_BITS);
               mode_in   = ALU_MUL;
            end else if (cmd.div_start) begin
               mcand_in = opa[WIDE-1] ? WIDE'(-opa) : opa;
               acc_in   = '0;
               q_in     = '0;
               ovf_in   = 1'b0;
               cnt_in   = CNT_BITS'(WIDE);
               mode_in  = ALU_DIV;
            end
         end
         ALU_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = sum[WIDE-1:0];
            end
            mcand_in  = {mcand_ff[WIDE-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[ELEMENT_BITS-1:1]};
            cnt_in    = cnt_ff - CNT_BITS'(1);
            if (last_step) begin
               mode_in = ALU_IDLE;
            end
         end
         ALU_DIV: begin
            acc_in   = sum[WIDE+1] ? sum[WIDE-1:0] : add_x[WIDE-1:0];
            mcand_in = {mcand_ff[WIDE-2:0], 1'b0};
            q_in     = {q_ff[ELEMENT_BITS-1:0], sum[WIDE+1]};
            ovf_in   = ovf_ff | q_ff[ELEMENT_BITS];
            cnt_in   = cnt_ff - CNT_BITS'(1);
            if (last_step) begin
               mode_in = ALU_IDLE;
            end
         end
         default: mode_in = ALU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ALU_IDLE;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      ovf_ff    <= ovf_in;
   end

   assign prod     = acc_ff;
   assign quot     = q_ff;
   assign quot_ovf = ovf_ff;
   assign busy     = (mode_ff != ALU_IDLE);

endmodule

>>> hdl/mat4_inverse_top.sv
// Top level of the 4x4 matrix inverse: element store, sequencer and result
// register. Depends on m4inv_pkg and m4inv_alu.
//
// A matrix arrives as 16 transactions in row-major order, one element per
// cycle while the block is loading. After the 16th element the block stops
// taking input and solves: each adjugate entry is six triple products formed
// by two serial multiplies each, the determinant needs four more such
// entries plus one multiply each, and every output element is one serial
// divide. The solve time is set by the single shared multiply/divide unit. A
// singular matrix gives one result with the singular flag and tlast set.
module mat4_inverse_top #(
   parameter int ELEMENT_BITS = m4inv_pkg::DEF_ELEMENT_BITS,
   parameter int FRAC_BITS    = m4inv_pkg::DEF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] element
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] inverse_element, [35:32] element_index
   output logic [1:0]  rsp_tuser,   // [0] singular, [1] saturated
   output logic        rsp_tlast
);
   import m4inv_pkg::*;

   localparam int WIDE = 4*ELEMENT_BITS + 2*FRAC_BITS + 4;
   localparam logic [ELEMENT_BITS:0] HALF = (ELEMENT_BITS+1)'(1) << (ELEMENT_BITS-1);

   state_type                       state_ff, state_in;
   logic [3:0]                      cnt_ff, cnt_in;
   logic [3:0]                      idx_ff, idx_in;
   logic [2:0]                      term_ff, term_in;
   logic                            phase_out_ff, phase_out_in;
   logic signed [ELEMENT_BITS-1:0]  a_ff, a_in;
   logic signed [ELEMENT_BITS-1:0]  rd_ff;
   logic signed [WIDE-1:0]          acc_ff, acc_in;
   logic signed [WIDE-1:0]          det_ff, det_in;
   logic        [WIDE-1:0]          det_mag_ff, det_mag_in;
   logic                            det_neg_ff, det_neg_in;
   logic                            num_neg_ff, num_neg_in;
   logic [31:0]                     out_elem_ff, out_elem_in;
   logic                            out_sat_ff, out_sat_in;
   logic                            out_sing_ff, out_sing_in;
   logic [ELEMENT_BITS-1:0]         mem [MAT_SIZE];
   logic                            rd_en;
   logic [3:0]                      rd_addr;
   logic                            req_accept;
   logic                            term_neg;
   alu_cmd_type                     alu_cmd;
   logic signed [WIDE-1:0]          alu_opa;
   logic signed [ELEMENT_BITS-1:0]  alu_opb;
   logic signed [WIDE-1:0]          alu_prod;
   logic [ELEMENT_BITS:0]           alu_quot;
   logic                            alu_ovf;
   logic                            alu_busy;
   logic                            q_neg, q_big;
   logic [ELEMENT_BITS:0]           q_mag;
   logic signed [ELEMENT_BITS-1:0]  q_val;

   m4inv_alu #(
      .ELEMENT_BITS(ELEMENT_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_alu (
      .clock   (clock),
      .reset   (reset),
      .cmd     (alu_cmd),
      .opa     (alu_opa),
      .opb     (alu_opb),
      .dmag    (det_mag_ff),
      .prod    (alu_prod),
      .quot    (alu_quot),
      .quot_ovf(alu_ovf),
      .busy    (alu_busy)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign term_neg   = perm_odd(term_ff) ^ idx_ff[2] ^ idx_ff[0];

   always_comb begin
      q_neg = num_neg_ff ^ det_neg_ff;
      if (q_neg) begin
         q_big = alu_ovf || (alu_quot > HALF);
         q_mag = q_big ? HALF : alu_quot;
         q_val = ELEMENT_BITS'(-q_mag);
      end else begin
         q_big = alu_ovf || (alu_quot > HALF - (ELEMENT_BITS+1)'(1));
         q_mag = q_big ? HALF - (ELEMENT_BITS+1)'(1) : alu_quot;
         q_val = ELEMENT_BITS'(q_mag);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      term_in      = term_ff;
      phase_out_in = phase_out_ff;
      a_in         = a_ff;
      acc_in       = acc_ff;
      det_in       = det_ff;
      det_mag_in   = det_mag_ff;
      det_neg_in   = det_neg_ff;
      num_neg_in   = num_neg_ff;
      out_elem_in  = out_elem_ff;
      out_sat_in   = out_sat_ff;
      out_sing_in  = out_sing_ff;
      rd_en        = 1'b0;
      rd_addr      = flat_index(idx_ff, term_ff, 2'd0);
      alu_cmd      = '0;
      alu_opa      = acc_ff;
      alu_opb      = rd_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  state_in     = ST_RD_A;
                  idx_in       = '0;
                  term_in      = '0;
                  phase_out_in = 1'b0;
                  det_in       = '0;
               end
            end
         end
         ST_RD_A: begin
            rd_en = 1'b1;
            if (term_ff == 3'd0) begin
               acc_in = '0;
            end
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            a_in     = rd_ff;
            rd_en    = 1'b1;
            rd_addr  = flat_index(idx_ff, term_ff, 2'd1);
            state_in = ST_MUL1_GO;
         end
         ST_MUL1_GO: begin
            alu_cmd.mul_start = 1'b1;
            alu_opa  = WIDE'(a_ff);
            rd_en    = 1'b1;
            rd_addr  = flat_index(idx_ff, term_ff, 2'd2);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            if (!alu_busy) begin
               alu_cmd.mul_start = 1'b1;
               alu_opa  = alu_prod;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (!alu_busy) begin
               acc_in = term_neg ? acc_ff - alu_prod : acc_ff + alu_prod;
               if (term_ff == 3'd5) begin
                  term_in  = '0;
                  state_in = ST_COF_DONE;
               end else begin
                  term_in  = term_ff + 3'd1;
                  state_in = ST_RD_A;
               end
            end
         end
         ST_COF_DONE: begin
            if (!phase_out_ff) begin
               rd_en    = 1'b1;
               rd_addr  = {2'b00, idx_ff[3:2]};
               state_in = ST_DET_GO;
            end else begin
               alu_cmd.div_start = 1'b1;
               alu_opa    = acc_ff <<< (2*FRAC_BITS);
               num_neg_in = acc_ff[WIDE-1];
               state_in   = ST_DIV;
            end
         end
         ST_DET_GO: begin
            alu_cmd.mul_start = 1'b1;
            state_in = ST_DET_MUL;
         end
         ST_DET_MUL: begin
            if (!alu_busy) begin
               det_in = det_ff + alu_prod;
               if (idx_ff == 4'd12) begin
                  idx_in   = '0;
                  state_in = ST_DET_CHECK;
               end else begin
                  idx_in   = idx_ff + 4'd4;
                  state_in = ST_RD_A;
               end
            end
         end
         ST_DET_CHECK: begin
            if (det_ff == '0) begin
               out_elem_in = '0;
               out_sat_in  = 1'b0;
               out_sing_in = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               det_mag_in   = det_ff[WIDE-1] ? WIDE'(-det_ff) : det_ff;
               det_neg_in   = det_ff[WIDE-1];
               phase_out_in = 1'b1;
               state_in     = ST_RD_A;
            end
         end
         ST_DIV: begin
            if (!alu_busy) begin
               out_elem_in = 32'(q_val);
               out_sat_in  = q_big;
               out_sing_in = 1'b0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (out_sing_ff || idx_ff == 4'd15) begin
                  idx_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = ST_RD_A;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         term_ff      <= '0;
         phase_out_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         term_ff      <= term_in;
         phase_out_ff <= phase_out_in;
      end
      a_ff        <= a_in;
      acc_ff      <= acc_in;
      det_ff      <= det_in;
      det_mag_ff  <= det_mag_in;
      det_neg_ff  <= det_neg_in;
      num_neg_ff  <= num_neg_in;
      out_elem_ff <= out_elem_in;
      out_sat_ff  <= out_sat_in;
      out_sing_ff <= out_sing_in;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mem[cnt_ff] <= req_tdata[ELEMENT_BITS-1:0];
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {4'b0000, idx_ff, out_elem_ff};
   assign rsp_tuser  = {out_sat_ff, out_sing_ff};
   assign rsp_tlast  = out_sing_ff || (idx_ff == 4'd15);

`ifndef SYNTHESIS
   a_sing_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("singular result without tlast");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[35:0] == 36'd0 && !rsp_tuser[1])
      else $error("singular result carries data");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid && !alu_busy)
      else $error("input taken while solving");
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      req_accept && cnt_ff == 4'd15 |=> !req_tready)
      else $error("ready after sixteenth element");
`endif

endmodule
